/* rtl/core/biq_pkg.sv */
// Shared constants, command/status types and register codes for the
// gliding-coefficient biquad. No dependencies.
package biq_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;
    localparam int STATE_BITS  = 48;

    localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
    localparam int COEF_FRAC   = COEF_BITS - 5;
    localparam int STATE_FRAC  = STATE_BITS - 8;
    localparam int XPROD_SHIFT = SAMPLE_FRAC + COEF_FRAC - STATE_FRAC;
    localparam int OUT_SHIFT   = STATE_FRAC - SAMPLE_FRAC;
    localparam int OY_BITS     = STATE_BITS - OUT_SHIFT;

    localparam int NCOEF         = 5;
    localparam int COEF_IDX_BITS = $clog2(NCOEF);
    localparam int CFG_REGS      = 8;
    localparam int CFG_IDX_BITS  = $clog2(CFG_REGS);
    localparam int CFG_DATA_BITS = COEF_BITS;
    localparam int CTL_BITS      = 16;

    localparam int GLIDE_SHIFT = 16;
    localparam int K_BITS      = GLIDE_SHIFT + 1;

    // y is multiplied in two halves: unsigned low, signed high
    localparam int YL_BITS = STATE_BITS / 2;
    localparam int YH_BITS = STATE_BITS - YL_BITS;

    localparam int MA_BITS   = COEF_BITS + 1;
    localparam int MB_BITS   = ((SAMPLE_BITS > YL_BITS) ? SAMPLE_BITS : YL_BITS) + 1;
    localparam int PROD_BITS = MA_BITS + MB_BITS;
    localparam int FULL_BITS = PROD_BITS + YL_BITS;
    localparam int ACC_BITS  = FULL_BITS - COEF_FRAC + 1;

    localparam logic signed [COEF_BITS-1:0] TGT_B0_RST = COEF_BITS'(1) << COEF_FRAC;
    localparam logic [CTL_BITS-1:0] GFAC_RST  = CTL_BITS'(65470);
    localparam logic [CTL_BITS-1:0] EPS_RST   = CTL_BITS'(134);
    localparam logic [CTL_BITS-1:0] FLUSH_RST = CTL_BITS'(1);

    localparam logic [CFG_IDX_BITS-1:0] REG_B0    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_B1    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_B2    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_A1    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_A2    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_GFAC  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_EPS   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_FLUSH = 3'd7;

    localparam logic [COEF_IDX_BITS-1:0] C_B0 = 3'd0;
    localparam logic [COEF_IDX_BITS-1:0] C_B1 = 3'd1;
    localparam logic [COEF_IDX_BITS-1:0] C_B2 = 3'd2;
    localparam logic [COEF_IDX_BITS-1:0] C_A1 = 3'd3;
    localparam logic [COEF_IDX_BITS-1:0] C_A2 = 3'd4;

    typedef logic [1:0] t_bsel;
    localparam t_bsel MB_X  = 2'd0;
    localparam t_bsel MB_YL = 2'd1;
    localparam t_bsel MB_YH = 2'd2;
    localparam t_bsel MB_K  = 2'd3;

    typedef struct packed {
        logic                     x_load;
        logic                     mul_en;
        logic [COEF_IDX_BITS-1:0] idx;
        logic                     a_diff;
        t_bsel                    b_sel;
        logic                     gl_step;
        logic                     gl_upd;
        logic                     gl_end;
        logic                     f_y;
        logic                     acc1_init;
        logic                     full_init;
        logic                     full_add;
        logic                     acc1_sub;
        logic                     acc2_init;
        logic                     acc2_sub;
        logic                     commit;
    } t_cmd;

    typedef struct packed {
        logic glide_active;
    } t_sts;

endpackage

/* rtl/core/biq_in_if.sv */
// Input sample channel: valid/ready with the sample payload.
// Depends on biq_pkg.
interface biq_in_if;
    import biq_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

/* rtl/core/biq_out_if.sv */
// Output sample channel: valid/ready with filtered sample and clip flag.
// Depends on biq_pkg.
interface biq_out_if;
    import biq_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

/* rtl/core/biq_dp.sv */
// Biquad datapath: config registers, coefficient glide, shared 33x25 multiplier,
// accumulators, delay states and output register. Depends on biq_pkg.
module biq_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [biq_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [biq_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic signed [biq_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  biq_pkg::t_cmd                        i_cmd,
    output biq_pkg::t_sts                        o_sts,
    output logic signed [biq_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                                 o_clipped
);
    import biq_pkg::*;

    localparam logic signed [PROD_BITS-1:0] RND = PROD_BITS'((1 << GLIDE_SHIFT) - 1);

    function automatic logic signed [STATE_BITS-1:0] sat_state(
        input logic signed [ACC_BITS-1:0] v);
        logic fits;
        fits = (&v[ACC_BITS-1:STATE_BITS-1]) || ~(|v[ACC_BITS-1:STATE_BITS-1]);
        if (fits) begin
            return v[STATE_BITS-1:0];
        end else if (v[ACC_BITS-1]) begin
            return {1'b1, {(STATE_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(STATE_BITS-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [STATE_BITS-1:0] flush_st(
        input logic signed [STATE_BITS-1:0] v, input logic [CTL_BITS-1:0] thr);
        logic [STATE_BITS-1:0] mag;
        mag = v[STATE_BITS-1] ? (~v + 1'b1) : v;
        return (mag < STATE_BITS'(thr)) ? '0 : v;
    endfunction

    function automatic logic [MA_BITS-1:0] abs_ma(input logic signed [MA_BITS-1:0] v);
        return v[MA_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    logic signed [COEF_BITS-1:0]   r_target [NCOEF];
    logic signed [COEF_BITS-1:0]   r_work   [NCOEF];
    logic [CTL_BITS-1:0]           r_gfac, r_eps, r_flush;
    logic                          r_glide, r_gl_ok;
    logic signed [STATE_BITS-1:0]  r_d1, r_d2;

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [MA_BITS-1:0]     r_step;
    logic signed [STATE_BITS-1:0]  r_y;
    logic signed [FULL_BITS-1:0]   r_full;
    logic signed [ACC_BITS-1:0]    r_acc1, r_acc2;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_clip;

    logic signed [MA_BITS-1:0]     w_diff, w_ma, w_strunc, w_stepv, w_wnew, w_ndiff;
    logic signed [MB_BITS-1:0]     w_mb;
    logic [K_BITS-1:0]             w_k;
    logic signed [PROD_BITS-1:0]   w_padj;
    logic signed [ACC_BITS-1:0]    w_px, w_fy;
    logic signed [OY_BITS-1:0]     w_yo;
    logic signed [SAMPLE_BITS-1:0] w_osat;
    logic                          w_oclip;
    logic                          w_far;
    logic signed [COEF_BITS-1:0]   w_tn;
    logic signed [MA_BITS-1:0]     w_cd;

    assign w_diff = MA_BITS'(r_target[i_cmd.idx]) - MA_BITS'(r_work[i_cmd.idx]);
    assign w_k    = K_BITS'(1 << GLIDE_SHIFT) - K_BITS'(r_gfac);
    assign w_ma   = i_cmd.a_diff ? w_diff : MA_BITS'(r_work[i_cmd.idx]);

    always_comb begin
        case (i_cmd.b_sel)
            MB_X:    w_mb = MB_BITS'(r_x);
            MB_YL:   w_mb = $signed(MB_BITS'(r_y[YL_BITS-1:0]));
            MB_YH:   w_mb = MB_BITS'($signed(r_y[STATE_BITS-1:YL_BITS]));
            default: w_mb = $signed(MB_BITS'(w_k));
        endcase
    end

    // trunc toward zero of k*d / 2^16, at least one LSB toward the target
    assign w_padj   = r_prod + (r_prod[PROD_BITS-1] ? RND : '0);
    assign w_strunc = $signed(w_padj[GLIDE_SHIFT +: MA_BITS]);
    always_comb begin
        w_stepv = w_strunc;
        if (w_strunc == '0 && w_diff != '0) begin
            w_stepv = w_diff[MA_BITS-1] ? -MA_BITS'(1) : MA_BITS'(1);
        end
    end
    assign w_wnew  = MA_BITS'(r_work[i_cmd.idx]) + r_step;
    assign w_ndiff = w_diff - r_step;

    assign w_px = ACC_BITS'($signed(r_prod[PROD_BITS-1:XPROD_SHIFT]));
    assign w_fy = ACC_BITS'($signed(r_full[FULL_BITS-1:COEF_FRAC]));

    assign w_yo = $signed(r_y[STATE_BITS-1:OUT_SHIFT]);
    always_comb begin
        w_oclip = !((&w_yo[OY_BITS-1:SAMPLE_BITS-1]) || ~(|w_yo[OY_BITS-1:SAMPLE_BITS-1]));
        if (!w_oclip) begin
            w_osat = w_yo[SAMPLE_BITS-1:0];
        end else if (w_yo[OY_BITS-1]) begin
            w_osat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            w_osat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // glide start check against the targets as they stand after this write
    always_comb begin
        w_far = 1'b0;
        w_tn  = '0;
        w_cd  = '0;
        for (int i = 0; i < NCOEF; i++) begin
            w_tn = (i_cfg_idx == CFG_IDX_BITS'(i)) ? $signed(i_cfg_data[COEF_BITS-1:0])
                                                   : r_target[i];
            w_cd = MA_BITS'(r_work[i]) - MA_BITS'(w_tn);
            if (abs_ma(w_cd) > MA_BITS'(r_eps)) begin
                w_far = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCOEF; i++) begin
                r_target[i] <= (i == 0) ? TGT_B0_RST : '0;
                r_work[i]   <= (i == 0) ? TGT_B0_RST : '0;
            end
            r_gfac  <= GFAC_RST;
            r_eps   <= EPS_RST;
            r_flush <= FLUSH_RST;
            r_glide <= 1'b0;
            r_gl_ok <= 1'b0;
            r_d1    <= '0;
            r_d2    <= '0;
        end else begin
            if (i_cmd.x_load) begin
                r_gl_ok <= 1'b1;
            end
            if (i_cmd.gl_upd) begin
                r_work[i_cmd.idx] <= w_wnew[COEF_BITS-1:0];
                if (abs_ma(w_ndiff) >= MA_BITS'(r_eps)) begin
                    r_gl_ok <= 1'b0;
                end
            end
            if (i_cmd.gl_end && r_gl_ok) begin
                for (int i = 0; i < NCOEF; i++) begin
                    r_work[i] <= r_target[i];
                end
                r_glide <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_d1 <= flush_st(sat_state(r_acc1), r_flush);
                r_d2 <= flush_st(sat_state(r_acc2), r_flush);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx) inside
                    REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: begin
                        for (int i = 0; i < NCOEF; i++) begin
                            if (i_cfg_idx == CFG_IDX_BITS'(i)) begin
                                r_target[i] <= $signed(i_cfg_data[COEF_BITS-1:0]);
                            end
                        end
                        r_glide <= w_far;
                    end
                    REG_GFAC:  r_gfac  <= i_cfg_data[CTL_BITS-1:0];
                    REG_EPS:   r_eps   <= i_cfg_data[CTL_BITS-1:0];
                    REG_FLUSH: r_flush <= i_cfg_data[CTL_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.x_load) begin
            r_x <= i_sample_in;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_ma * w_mb;
        end
        if (i_cmd.gl_step) begin
            r_step <= w_stepv;
        end
        if (i_cmd.f_y) begin
            r_y <= sat_state(w_px + ACC_BITS'(r_d1));
        end
        if (i_cmd.acc1_init) begin
            r_acc1 <= w_px + ACC_BITS'(r_d2);
        end else if (i_cmd.acc1_sub) begin
            r_acc1 <= r_acc1 - w_fy;
        end
        if (i_cmd.acc2_init) begin
            r_acc2 <= w_px;
        end else if (i_cmd.acc2_sub) begin
            r_acc2 <= r_acc2 - w_fy;
        end
        if (i_cmd.full_init) begin
            r_full <= FULL_BITS'(r_prod);
        end else if (i_cmd.full_add) begin
            r_full <= r_full + (FULL_BITS'(r_prod) <<< YL_BITS);
        end
        if (i_cmd.commit) begin
            r_out_sample <= w_osat;
            r_out_clip   <= w_oclip;
        end
    end

    assign o_sts.glide_active = r_glide;
    assign o_sample_out       = r_out_sample;
    assign o_clipped          = r_out_clip;

endmodule

/* rtl/core/biq_ctrl.sv */
// Biquad controller: sequences the coefficient glide and the filter steps,
// and owns the input ready and output valid. Depends on biq_pkg.
module biq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  biq_pkg::t_sts i_sts,
    output biq_pkg::t_cmd o_cmd
);
    import biq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GMUL  = 3'd1;
    localparam logic [2:0] S_GSTEP = 3'd2;
    localparam logic [2:0] S_GUPD  = 3'd3;
    localparam logic [2:0] S_GEND  = 3'd4;
    localparam logic [2:0] S_FILT  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam logic [3:0] F_B0X   = 4'd0;
    localparam logic [3:0] F_B1X   = 4'd1;
    localparam logic [3:0] F_A1YL  = 4'd2;
    localparam logic [3:0] F_A1YH  = 4'd3;
    localparam logic [3:0] F_B2X   = 4'd4;
    localparam logic [3:0] F_A2YL  = 4'd5;
    localparam logic [3:0] F_A2YH  = 4'd6;
    localparam logic [3:0] F_FADD  = 4'd7;
    localparam logic [3:0] F_LAST  = 4'd8;

    localparam logic [COEF_IDX_BITS-1:0] C_LAST = COEF_IDX_BITS'(NCOEF - 1);

    logic [2:0]               r_state, n_state;
    logic [COEF_IDX_BITS-1:0] r_cidx, n_cidx;
    logic [3:0]               r_fstep, n_fstep;
    logic                     r_ovld, n_ovld;
    t_cmd                     w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        n_cidx  = r_cidx;
        n_fstep = r_fstep;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.x_load = i_in_valid;
                if (i_in_valid) begin
                    n_cidx  = '0;
                    n_fstep = F_B0X;
                    n_state = i_sts.glide_active ? S_GMUL : S_FILT;
                end
            end
            S_GMUL: begin
                w_cmd.mul_en = 1'b1;
                w_cmd.a_diff = 1'b1;
                w_cmd.b_sel  = MB_K;
                w_cmd.idx    = r_cidx;
                n_state      = S_GSTEP;
            end
            S_GSTEP: begin
                w_cmd.gl_step = 1'b1;
                w_cmd.idx     = r_cidx;
                n_state       = S_GUPD;
            end
            S_GUPD: begin
                w_cmd.gl_upd = 1'b1;
                w_cmd.idx    = r_cidx;
                if (r_cidx == C_LAST) begin
                    n_state = S_GEND;
                end else begin
                    n_cidx  = r_cidx + 1'b1;
                    n_state = S_GMUL;
                end
            end
            S_GEND: begin
                w_cmd.gl_end = 1'b1;
                n_fstep      = F_B0X;
                n_state      = S_FILT;
            end
            S_FILT: begin
                n_fstep = r_fstep + 1'b1;
                unique case (r_fstep)
                    F_B0X: begin
                        w_cmd.mul_en = 1'b1;
                        w_cmd.idx    = C_B0;
                        w_cmd.b_sel  = MB_X;
                    end
                    F_B1X: begin
                        w_cmd.f_y    = 1'b1;
                        w_cmd.mul_en = 1'b1;
                        w_cmd.idx    = C_B1;
                        w_cmd.b_sel  = MB_X;
                    end
                    F_A1YL: begin
                        w_cmd.acc1_init = 1'b1;
                        w_cmd.mul_en    = 1'b1;
                        w_cmd.idx       = C_A1;
                        w_cmd.b_sel     = MB_YL;
                    end
                    F_A1YH: begin
                        w_cmd.full_init = 1'b1;
                        w_cmd.mul_en    = 1'b1;
                        w_cmd.idx       = C_A1;
                        w_cmd.b_sel     = MB_YH;
                    end
                    F_B2X: begin
                        w_cmd.full_add = 1'b1;
                        w_cmd.mul_en   = 1'b1;
                        w_cmd.idx      = C_B2;
                        w_cmd.b_sel    = MB_X;
                    end
                    F_A2YL: begin
                        w_cmd.acc1_sub  = 1'b1;
                        w_cmd.acc2_init = 1'b1;
                        w_cmd.mul_en    = 1'b1;
                        w_cmd.idx       = C_A2;
                        w_cmd.b_sel     = MB_YL;
                    end
                    F_A2YH: begin
                        w_cmd.full_init = 1'b1;
                        w_cmd.mul_en    = 1'b1;
                        w_cmd.idx       = C_A2;
                        w_cmd.b_sel     = MB_YH;
                    end
                    F_FADD: begin
                        w_cmd.full_add = 1'b1;
                    end
                    F_LAST: begin
                        w_cmd.acc2_sub = 1'b1;
                        n_state        = S_FIN;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_FIN: begin
                if (!r_ovld || i_out_ready) begin
                    w_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovld = r_ovld;
        if (w_cmd.commit) begin
            n_ovld = 1'b1;
        end else if (i_out_ready) begin
            n_ovld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cidx  <= '0;
            r_fstep <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cidx  <= n_cidx;
            r_fstep <= n_fstep;
            r_ovld  <= n_ovld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_cmd       = w_cmd;

endmodule

/* rtl/core/biquad_tdf2_coef_glide_top.sv */
// Top level of the gliding-coefficient biquad: controller plus datapath.
// Depends on biq_pkg, biq_in_if, biq_out_if, biq_ctrl, biq_dp.
//
//   port        dir   handshake      payload
//   i_in_s      in    valid/ready    sample_in  (s24 Q1.23)
//   o_out_s     out   valid/ready    sample_out (s24 Q1.23), clipped
//   i_cfg_*     in    write enable   idx (3b), data (32b)
//
// While a glide runs, each sample first passes the five coefficients through a
// multiply, step and update state each and then one end step, before the filter
// steps; every product goes through the single shared 33x25 multiplier in biq_dp.
// Reset is synchronous, active low; it restores unity passthrough and zero delays.
// The next sample is taken while a result waits in the output register; the
// sequencer holds in its final step until that register is free.
module biquad_tdf2_coef_glide_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    biq_in_if.sink                             i_in_s,
    biq_out_if.source                          o_out_s,
    input  logic                               i_cfg_we,
    input  logic [biq_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [biq_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import biq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;
    logic w_out_valid;

    biq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_s.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_out_s.ready),
        .o_out_valid (w_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    biq_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_in_s.sample_in),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_sample_out (o_out_s.sample_out),
        .o_clipped    (o_out_s.clipped)
    );

    assign i_in_s.ready  = w_in_ready;
    assign o_out_s.valid = w_out_valid;

`ifndef SYNTH
    a_no_back_to_back_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_s.valid && w_in_ready) |=> !w_in_ready)
        else $error("input taken on consecutive cycles");

    a_commit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!w_out_valid || o_out_s.ready))
        else $error("result overwritten before transfer");

    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> w_out_valid)
        else $error("committed result not presented");

    a_glide_stop_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(w_sts.glide_active) |-> $past(w_cmd.gl_end || i_cfg_we))
        else $error("glide stopped without end step or write");
`endif

endmodule

/* bench/testbench.sv */
// Self-checking bench for biquad_tdf2_coef_glide_top: a scoreboard class predicts
// every output bit-exactly (glide, TDF2 step, flush, saturation) from the inputs.
// Depends on biq_pkg, biq_in_if, biq_out_if and the biquad RTL.
module testbench;
    import biq_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 4;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 24;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [CFG_DATA_BITS-1:0]      cfg_word_t;

    typedef struct packed {
        sample_t sample;
        logic    clip;
    } filt_out_t;

    localparam sample_t   MAX_S    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t   MIN_S    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam cfg_word_t COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam cfg_word_t COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic [CFG_IDX_BITS-1:0] COEF_REGS [NCOEF] =
        '{REG_B0, REG_B1, REG_B2, REG_A1, REG_A2};

    class biquad_scoreboard;
        longint    tgt[NCOEF];
        longint    coef[NCOEF];
        longint    gfac, eps, flush_lim;
        longint    z1, z2;
        bit        gliding;
        filt_out_t pending[$];
        int        errors;

        function new();
            foreach (tgt[i]) tgt[i] = 0;
            tgt[C_B0] = TGT_B0_RST;
            foreach (coef[i]) coef[i] = tgt[i];
            gfac      = GFAC_RST;
            eps       = EPS_RST;
            flush_lim = FLUSH_RST;
            z1        = 0;
            z2        = 0;
            gliding   = 0;
            errors    = 0;
        endfunction

        // exact product, floor-shifted
        function longint mul_floor(longint a, longint b, int sh);
            logic signed [127:0] pa, pb;
            pa = a;
            pb = b;
            pa = (pa * pb) >>> sh;
            return pa[63:0];
        endfunction

        function longint clamp(longint v, int bits, output bit hit);
            longint hi, lo;
            hi  = (longint'(1) <<< (bits - 1)) - 1;
            lo  = -hi - 1;
            hit = 0;
            if (v > hi) begin
                hit = 1;
                return hi;
            end
            if (v < lo) begin
                hit = 1;
                return lo;
            end
            return v;
        endfunction

        function longint abs_gap(longint a, longint b);
            return (a >= b) ? a - b : b - a;
        endfunction

        function longint flushed(longint v);
            longint mag;
            mag = (v < 0) ? -v : v;
            return (mag < flush_lim) ? 0 : v;
        endfunction

        function void apply_reg(logic [CFG_IDX_BITS-1:0] idx, cfg_word_t data);
            logic signed [COEF_BITS-1:0] sdata;
            sdata = data;
            case (idx)
                REG_B0, REG_B1, REG_B2, REG_A1, REG_A2: begin
                    tgt[idx] = sdata;
                    gliding  = 0;
                    foreach (coef[i])
                        if (abs_gap(coef[i], tgt[i]) > eps) gliding = 1;
                end
                REG_GFAC:  gfac      = data[CTL_BITS-1:0];
                REG_EPS:   eps       = data[CTL_BITS-1:0];
                REG_FLUSH: flush_lim = data[CTL_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void glide_step();
            longint k, d, st;
            bit     done;
            k    = (longint'(1) << GLIDE_SHIFT) - gfac;
            done = 1;
            foreach (coef[i]) begin
                d  = tgt[i] - coef[i];
                st = (k * d) / (longint'(1) << GLIDE_SHIFT);
                if (st == 0 && d != 0) st = (d > 0) ? 1 : -1;
                coef[i] += st;
                if (abs_gap(coef[i], tgt[i]) >= eps) done = 0;
            end
            if (done) begin
                foreach (coef[i]) coef[i] = tgt[i];
                gliding = 0;
            end
        endfunction

        function void note_sample(sample_t x_in);
            longint    x, y, n1, n2, o;
            bit        hit, unused;
            filt_out_t want;
            if (gliding) glide_step();
            x  = x_in;
            y  = clamp(mul_floor(coef[C_B0], x, XPROD_SHIFT) + z1, STATE_BITS, unused);
            n1 = mul_floor(coef[C_B1], x, XPROD_SHIFT)
                 - mul_floor(coef[C_A1], y, COEF_FRAC) + z2;
            n2 = mul_floor(coef[C_B2], x, XPROD_SHIFT)
                 - mul_floor(coef[C_A2], y, COEF_FRAC);
            z1 = flushed(clamp(n1, STATE_BITS, unused));
            z2 = flushed(clamp(n2, STATE_BITS, unused));
            o  = clamp(y >>> OUT_SHIFT, SAMPLE_BITS, hit);
            want.sample = o[SAMPLE_BITS-1:0];
            want.clip   = hit;
            pending.push_back(want);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        task check_output(sample_t got, logic got_clip);
            filt_out_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("output %0d with nothing pending", got));
                return;
            end
            want = pending.pop_front();
            if (got !== want.sample)
                report_mismatch($sformatf("sample_out %0d, want %0d", got, want.sample));
            if (got_clip !== want.clip)
                report_mismatch($sformatf("clipped %b, want %b", got_clip, want.clip));
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_idx;
    cfg_word_t               cfg_data;
    bit                      in_calm  = 1'b0;
    bit                      out_calm = 1'b0;
    int                      stall_cycles = 0;
    biquad_scoreboard        sb;

    biq_in_if  in_ch();
    biq_out_if out_ch();

    biquad_tdf2_coef_glide_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_s     (in_ch),
        .o_out_s    (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, cfg_word_t data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.apply_reg(idx, data);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // hold: stop feeding until every pending output has come back
    task automatic send_sample(sample_t s, bit hold);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0 || hold) begin
            in_ch.valid <= 1'b0;
            if (hold) begin
                @(posedge i_clk);
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_sample(s);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0:       return MAX_S;
            1:       return MIN_S;
            2, 3:    return sample_t'(int'($urandom_range(0, 600)) - 300);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic cfg_word_t pick_coef();
        case ($urandom_range(0, 9))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return $urandom;
            3:       return TGT_B0_RST;
            default: return cfg_word_t'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
        endcase
    endfunction

    function automatic cfg_word_t pick_tap();
        return cfg_word_t'(int'($urandom_range(0, 1 << 28)) - (1 << 27));
    endfunction

    // upper data bits are random; only the low 16 count
    function automatic cfg_word_t pick_ctl(int lo, int hi);
        cfg_word_t w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0:       w[CTL_BITS-1:0] = '0;
            1:       w[CTL_BITS-1:0] = '1;
            2:       w[CTL_BITS-1:0] = CTL_BITS'($urandom);
            default: w[CTL_BITS-1:0] = CTL_BITS'($urandom_range(lo, hi));
        endcase
        return w;
    endfunction

    // poles inside the stability triangle: |a2| < 0.9, |a1| < 0.95 * (1 + a2)
    task automatic load_stable_biquad();
        longint a1, a2, lim;
        a2  = longint'($urandom_range(0, 241591910)) - 120795955;
        lim = (((longint'(1) << COEF_FRAC) + a2) * 95) / 100;
        a1  = longint'($urandom_range(0, 32'(2 * lim))) - lim;
        write_reg(REG_B0, pick_tap());
        write_reg(REG_B1, pick_tap());
        write_reg(REG_B2, pick_tap());
        write_reg(REG_A1, cfg_word_t'(a1));
        write_reg(REG_A2, cfg_word_t'(a2));
    endtask

    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = out_calm ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            sb.check_output(out_ch.sample_out, out_ch.clipped);
        end
    end

    initial begin
        sb = new();
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        cfg_we          <= 1'b0;
        cfg_idx         <= '0;
        cfg_data        <= '0;
        i_rst_n         <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unity passthrough out of reset
        send_sample(MAX_S, 0);
        send_sample(MIN_S, 0);
        send_sample('0, 0);
        send_sample(sample_t'(1), 0);
        send_sample(sample_t'(-1), 0);
        in_ch.valid <= 1'b0;
        wait_drained();

        // extreme coefficients, instant glide: output clip and delay saturation
        write_reg(REG_GFAC, '0);
        write_reg(REG_B0, COEF_MAX);
        write_reg(REG_B1, COEF_MIN);
        write_reg(REG_B2, COEF_MAX);
        write_reg(REG_A1, COEF_MIN);
        write_reg(REG_A2, COEF_MAX);
        write_reg(REG_FLUSH, '0);
        send_sample(MAX_S, 0);
        send_sample(MIN_S, 0);
        send_sample(MAX_S, 0);
        send_sample('0, 0);
        send_sample(MIN_S, 0);
        in_ch.valid <= 1'b0;
        wait_drained();

        // glide back to unity, ends in a snap
        write_reg(REG_GFAC, cfg_word_t'(8192));
        write_reg(REG_B0, TGT_B0_RST);
        write_reg(REG_B1, '0);
        write_reg(REG_B2, '0);
        write_reg(REG_A1, '0);
        write_reg(REG_A2, '0);
        repeat (10) send_sample(pick_sample(), 0);
        in_ch.valid <= 1'b0;
        wait_drained();

        // steps that truncate to zero move one LSB; wide flush window
        write_reg(REG_FLUSH, cfg_word_t'(16'hffff));
        write_reg(REG_EPS, cfg_word_t'(2));
        write_reg(REG_GFAC, cfg_word_t'(16'hffff));
        write_reg(REG_B1, cfg_word_t'(3));
        send_sample(sample_t'(300), 0);
        send_sample(sample_t'(-300), 0);
        send_sample(MAX_S, 0);
        send_sample(sample_t'(-5), 0);
        in_ch.valid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) != 0)
                load_stable_biquad();
            else
                repeat ($urandom_range(1, 5))
                    write_reg(COEF_REGS[$urandom_range(0, NCOEF - 1)], pick_coef());
            if ($urandom_range(0, 1)) write_reg(REG_GFAC, pick_ctl(60000, 65535));
            if ($urandom_range(0, 1)) write_reg(REG_EPS, pick_ctl(0, 500));
            if ($urandom_range(0, 1)) write_reg(REG_FLUSH, pick_ctl(0, 300));
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample(), $urandom_range(0, 19) == 0);
            in_ch.valid <= 1'b0;
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
